[design/stack_cpu16_step_macros.svh]
// Assertion macros for the 16-bit stack processor step block.
`ifndef STACK_CPU16_STEP_MACROS_SVH
`define STACK_CPU16_STEP_MACROS_SVH
`ifndef SYNTH
// Implication in the same cycle.
`define SC16_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Implication in the next cycle.
`define SC16_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define SC16_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define SC16_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

[design/sc16_pkg.sv]
// Shared constants, opcodes and types of the 16-bit stack processor step block.
package sc16_pkg;

   localparam int ADDR_BITS    = 16;
   localparam int MEM_BYTES    = 1 << ADDR_BITS;
   localparam int STACK_WORDS  = 126;
   localparam int SP_BITS      = $clog2(STACK_WORDS + 1);
   localparam int STK_IDX_BITS = (STACK_WORDS > 1) ? $clog2(STACK_WORDS) : 1;
   localparam int DEPTH_W      = 7;

   localparam logic [15:0] ALL_ONES  = 16'hffff;
   localparam logic [15:0] HALT_CODE = 16'd99;

   // Command codes.
   localparam logic [1:0] FN_EXEC  = 2'd0;
   localparam logic [1:0] FN_WRITE = 2'd1;
   localparam logic [1:0] FN_READ  = 2'd2;
   localparam logic [1:0] FN_SETPC = 2'd3;

   // Status codes.
   localparam logic [2:0] ST_OK    = 3'd0;
   localparam logic [2:0] ST_HALT  = 3'd1;
   localparam logic [2:0] ST_UNDER = 3'd2;
   localparam logic [2:0] ST_OVER  = 3'd3;
   localparam logic [2:0] ST_BADOP = 3'd4;

   // Opcodes.
   localparam logic [7:0] OP_NOP     = 8'd0;
   localparam logic [7:0] OP_PUSH    = 8'd1;
   localparam logic [7:0] OP_DUP     = 8'd2;
   localparam logic [7:0] OP_PUSHI   = 8'd3;
   localparam logic [7:0] OP_PUSHII  = 8'd4;
   localparam logic [7:0] OP_PUSHS   = 8'd5;
   localparam logic [7:0] OP_POPNULL = 8'd6;
   localparam logic [7:0] OP_SWP     = 8'd7;
   localparam logic [7:0] OP_POPI    = 8'd8;
   localparam logic [7:0] OP_POPII   = 8'd9;
   localparam logic [7:0] OP_POPS    = 8'd10;
   localparam logic [7:0] OP_CMP     = 8'd11;
   localparam logic [7:0] OP_CMPS    = 8'd12;
   localparam logic [7:0] OP_CMPI    = 8'd13;
   localparam logic [7:0] OP_CMPII   = 8'd14;
   localparam logic [7:0] OP_ADD     = 8'd15;
   localparam logic [7:0] OP_ADDS    = 8'd16;
   localparam logic [7:0] OP_ADDI    = 8'd17;
   localparam logic [7:0] OP_ADDII   = 8'd18;
   localparam logic [7:0] OP_SUB     = 8'd19;
   localparam logic [7:0] OP_SUBS    = 8'd20;
   localparam logic [7:0] OP_SUBI    = 8'd21;
   localparam logic [7:0] OP_SUBII   = 8'd22;
   localparam logic [7:0] OP_OR      = 8'd23;
   localparam logic [7:0] OP_ORS     = 8'd24;
   localparam logic [7:0] OP_ORI     = 8'd25;
   localparam logic [7:0] OP_ORII    = 8'd26;
   localparam logic [7:0] OP_AND     = 8'd27;
   localparam logic [7:0] OP_ANDS    = 8'd28;
   localparam logic [7:0] OP_ANDI    = 8'd29;
   localparam logic [7:0] OP_ANDII   = 8'd30;
   localparam logic [7:0] OP_XOR     = 8'd31;
   localparam logic [7:0] OP_XORS    = 8'd32;
   localparam logic [7:0] OP_XORI    = 8'd33;
   localparam logic [7:0] OP_XORII   = 8'd34;
   localparam logic [7:0] OP_JMPZ    = 8'd35;
   localparam logic [7:0] OP_JMPN    = 8'd36;
   localparam logic [7:0] OP_JMPC    = 8'd37;
   localparam logic [7:0] OP_JMPO    = 8'd38;
   localparam logic [7:0] OP_JMP     = 8'd39;
   localparam logic [7:0] OP_JMPI    = 8'd40;
   localparam logic [7:0] OP_JMPS    = 8'd41;
   localparam logic [7:0] OP_CAST    = 8'd42;
   localparam logic [7:0] OP_POLL    = 8'd43;
   localparam logic [7:0] OP_RRTC    = 8'd44;
   localparam logic [7:0] OP_RLTC    = 8'd45;
   localparam logic [7:0] OP_RTR     = 8'd46;
   localparam logic [7:0] OP_RTL     = 8'd47;
   localparam logic [7:0] OP_INV     = 8'd48;
   localparam logic [7:0] OP_COMP2   = 8'd49;
   localparam logic [7:0] OP_FCLR    = 8'd50;
   localparam logic [7:0] OP_FSAV    = 8'd51;
   localparam logic [7:0] OP_FLOD    = 8'd52;

   // Sequencer states, one-hot.
   typedef enum logic [18:0] {
      S_IDLE = 19'h00001,
      S_RB   = 19'h00002,
      S_OP   = 19'h00004,
      S_P0   = 19'h00008,
      S_P1   = 19'h00010,
      S_I0   = 19'h00020,
      S_I1   = 19'h00040,
      S_J0   = 19'h00080,
      S_J1   = 19'h00100,
      S_CAP  = 19'h00200,
      S_CALC = 19'h00400,
      S_SR0  = 19'h00800,
      S_SR1  = 19'h01000,
      S_SR2  = 19'h02000,
      S_W1   = 19'h04000,
      S_W2   = 19'h08000,
      S_TOP  = 19'h10000,
      S_TOPC = 19'h20000,
      S_RESP = 19'h40000
   } state_type;

   // Write-back plan produced by the execute step.
   typedef struct packed {
      logic                    wr0;
      logic                    wr1;
      logic [STK_IDX_BITS-1:0] w0;
      logic [STK_IDX_BITS-1:0] w1;
      logic [15:0]             v1;
      logic                    mw;
      logic                    rd16;
      logic [15:0]             mw_addr;
      logic [15:0]             mw_val;
   } plan_type;

endpackage

[design/stack_cpu16_if.sv]
// Valid/ready channel interfaces for the request and response items.
interface stack_cpu16_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [15:0] address;
   logic [7:0]  write_byte;

   modport source (output valid, func, address, write_byte, input ready);
   modport sink   (input valid, func, address, write_byte, output ready);
endinterface

interface stack_cpu16_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] pc_out;
   logic [3:0]  flags_out;
   logic [2:0]  status;
   logic [7:0]  read_byte;
   logic [15:0] top_word;
   logic [6:0]  stack_depth;

   modport source (output valid, pc_out, flags_out, status, read_byte, top_word,
                   stack_depth, input ready);
   modport sink   (input valid, pc_out, flags_out, status, read_byte, top_word,
                   stack_depth, output ready);
endinterface

[design/stack_cpu16_step.sv]
// Top level of the 16-bit stack processor step block.
//
// Usage: each item on req_chan is one command: execute one instruction at
// the program counter, write a memory byte, read a memory byte, or set the
// program counter. Exactly one item comes back on rsp_chan for each
// command, carrying the program counter, flags, status, the byte read, the
// word on top of the stack and the stack depth after the command.
// The block works on one command at a time: req_chan.ready is high only
// while it is idle. All memory traffic goes through one byte memory port
// and one stack word port, so an instruction walks a sequence of dependent
// reads (opcode, two parameter bytes, two indirect bytes, two double
// indirect bytes) before one shared adder/logic step computes the result.
// An execute walks S_OP, S_P0, S_P1, S_I0, S_I1, S_J0, S_J1, S_CAP, S_CALC,
// S_W1, S_W2, S_TOP and S_TOPC to the response (the stack-indirect push adds
// S_SR0 to S_SR2 after S_CALC); a byte write or set-PC goes through S_TOP
// and S_TOPC, a read through S_RB first, and a new command waits until the response is taken.
// The response item is held in registers until rsp_chan.ready is seen; a
// stalled receiver simply holds the block in its response state.
// Synchronous reset clears the stack depth, program counter, flags and the
// sequencer. The byte memory and the stack store are not cleared: reading
// an entry that was never written gives an unspecified value.
module stack_cpu16_step (
   input logic               clock,
   input logic               reset,
   stack_cpu16_req_if.sink   req_chan,
   stack_cpu16_rsp_if.source rsp_chan
);

   // Sequencer and architectural state.
   sc16_pkg::state_type state_ff, state_in;
   logic [15:0] pc_ff, pc_in;
   logic [3:0]  flags_ff, flags_in;
   logic [sc16_pkg::SP_BITS-1:0] sp_ff, sp_in;
   logic [2:0]  status_ff, status_in;
   logic [7:0]  rbyte_ff, rbyte_in;
   logic [15:0] top_ff, top_in;

   // Fetched operands.
   logic [7:0]  op_ff, op_in;
   logic [7:0]  lo_ff, lo_in;
   logic [15:0] tos_ff, tos_in;
   logic [15:0] sft_ff, sft_in;
   logic [15:0] p_ff, p_in;
   logic [15:0] pi_ff, pi_in;
   logic [15:0] pii_ff, pii_in;
   logic [15:0] v0_ff, v0_in;
   sc16_pkg::plan_type plan_ff, plan_in;

   // Memory ports.
   logic [7:0]  mem [sc16_pkg::MEM_BYTES];
   logic        mem_we;
   logic [15:0] mem_addr;
   logic [7:0]  mem_wd;
   logic [7:0]  mem_q;
   logic [15:0] stk [sc16_pkg::STACK_WORDS];
   logic        stk_we;
   logic [sc16_pkg::STK_IDX_BITS-1:0] stk_addr;
   logic [15:0] stk_wd;
   logic [15:0] stk_q;

   // Execute step results.
   sc16_pkg::plan_type calc_plan;
   logic [15:0] calc_v0;
   logic [15:0] calc_pc;
   logic [3:0]  calc_flags;
   logic [2:0]  calc_st;
   logic [sc16_pkg::SP_BITS-1:0] calc_sp;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr[sc16_pkg::ADDR_BITS-1:0]] <= mem_wd;
      end
      mem_q <= mem[mem_addr[sc16_pkg::ADDR_BITS-1:0]];
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk[stk_addr] <= stk_wd;
      end
      stk_q <= stk[stk_addr];
   end

   // One shared add/subtract and logic unit plus the stack bookkeeping.
   always_comb begin
      logic [15:0] a_eff, b_eff, opnd, alu_x, alu_y, lg_y, lg_r, rot_r, tgt;
      logic [16:0] alu_r;
      logic        alu_sub, alu_o, take;
      logic [3:0]  alu_f;
      logic [1:0]  npop, npush, size;
      logic        under;
      logic [sc16_pkg::SP_BITS-1:0] base;

      a_eff = (sp_ff >= sc16_pkg::SP_BITS'(1)) ? tos_ff : sc16_pkg::ALL_ONES;
      b_eff = (sp_ff >= sc16_pkg::SP_BITS'(2)) ? sft_ff : sc16_pkg::ALL_ONES;

      case (op_ff) inside
         sc16_pkg::OP_CMP, sc16_pkg::OP_ADD, sc16_pkg::OP_SUB,
         sc16_pkg::OP_OR, sc16_pkg::OP_AND, sc16_pkg::OP_XOR: opnd = p_ff;
         sc16_pkg::OP_CMPI, sc16_pkg::OP_ADDI, sc16_pkg::OP_SUBI,
         sc16_pkg::OP_ORI, sc16_pkg::OP_ANDI, sc16_pkg::OP_XORI: opnd = pi_ff;
         sc16_pkg::OP_CMPII, sc16_pkg::OP_ADDII, sc16_pkg::OP_SUBII,
         sc16_pkg::OP_ORII, sc16_pkg::OP_ANDII, sc16_pkg::OP_XORII: opnd = pii_ff;
         default: opnd = 16'd0;
      endcase

      // Operand routing into the adder.
      alu_x   = a_eff;
      alu_y   = opnd;
      alu_sub = 1'b1;
      case (op_ff) inside
         sc16_pkg::OP_CMPS, sc16_pkg::OP_SUBS: begin
            alu_x = b_eff;
            alu_y = a_eff;
         end
         sc16_pkg::OP_ADD, sc16_pkg::OP_ADDI, sc16_pkg::OP_ADDII: begin
            alu_x   = opnd;
            alu_y   = a_eff;
            alu_sub = 1'b0;
         end
         sc16_pkg::OP_ADDS: begin
            alu_x   = a_eff;
            alu_y   = b_eff;
            alu_sub = 1'b0;
         end
         sc16_pkg::OP_COMP2: begin
            alu_x = 16'd0;
            alu_y = a_eff;
         end
         default: ;
      endcase
      alu_r = alu_sub ? ({1'b0, alu_x} - {1'b0, alu_y}) : ({1'b0, alu_x} + {1'b0, alu_y});
      alu_o = alu_sub ? ((alu_x[15] != alu_y[15]) && (alu_r[15] != alu_x[15]))
                      : ((alu_x[15] == alu_y[15]) && (alu_r[15] != alu_x[15]));
      alu_f = {alu_o, alu_r[16], alu_r[15], (alu_r[15:0] == 16'd0)};

      // Logic unit: stack forms combine the two top words.
      case (op_ff) inside
         sc16_pkg::OP_ORS, sc16_pkg::OP_ANDS, sc16_pkg::OP_XORS: lg_y = b_eff;
         default: lg_y = opnd;
      endcase
      case (op_ff) inside
         sc16_pkg::OP_OR, sc16_pkg::OP_ORS, sc16_pkg::OP_ORI,
         sc16_pkg::OP_ORII: lg_r = a_eff | lg_y;
         sc16_pkg::OP_AND, sc16_pkg::OP_ANDS, sc16_pkg::OP_ANDI,
         sc16_pkg::OP_ANDII: lg_r = a_eff & lg_y;
         sc16_pkg::OP_INV: lg_r = ~a_eff;
         sc16_pkg::OP_COMP2: lg_r = alu_r[15:0];
         default: lg_r = a_eff ^ lg_y;
      endcase

      case (op_ff) inside
         sc16_pkg::OP_RRTC: rot_r = {flags_ff[2], a_eff[15:1]};
         sc16_pkg::OP_RLTC: rot_r = {a_eff[14:0], flags_ff[2]};
         sc16_pkg::OP_RTR:  rot_r = {1'b0, a_eff[15:1]};
         default:           rot_r = {a_eff[14:0], 1'b0};
      endcase

      npop       = 2'd0;
      npush      = 2'd0;
      size       = 2'd1;
      take       = 1'b0;
      tgt        = p_ff;
      calc_v0    = a_eff;
      calc_flags = flags_ff;
      calc_st    = sc16_pkg::ST_OK;
      calc_plan  = '0;
      calc_plan.v1 = b_eff;

      case (op_ff) inside
         sc16_pkg::OP_NOP: ;
         sc16_pkg::OP_PUSH: begin
            npush = 2'd1; calc_v0 = p_ff; size = 2'd3;
         end
         sc16_pkg::OP_DUP: npush = 2'd1;
         sc16_pkg::OP_PUSHI: begin
            npush = 2'd1; calc_v0 = pi_ff; size = 2'd3;
         end
         sc16_pkg::OP_PUSHII: begin
            npush = 2'd1; calc_v0 = pii_ff; size = 2'd3;
         end
         sc16_pkg::OP_PUSHS: begin
            npop = 2'd1; npush = 2'd1;
            calc_plan.rd16 = 1'b1; calc_plan.mw_addr = a_eff;
         end
         sc16_pkg::OP_POPNULL: npop = 2'd1;
         sc16_pkg::OP_SWP: begin
            npop = 2'd2; npush = 2'd2;
         end
         sc16_pkg::OP_POPI, sc16_pkg::OP_POPII: begin
            npop = 2'd1; size = 2'd3;
            calc_plan.mw = 1'b1;
            calc_plan.mw_addr = (op_ff == sc16_pkg::OP_POPI) ? p_ff : pi_ff;
            calc_plan.mw_val = a_eff;
         end
         sc16_pkg::OP_POPS: begin
            npop = 2'd2;
            calc_plan.mw = 1'b1; calc_plan.mw_addr = a_eff; calc_plan.mw_val = b_eff;
         end
         sc16_pkg::OP_CMP, sc16_pkg::OP_CMPI, sc16_pkg::OP_CMPII: begin
            calc_flags = alu_f; size = 2'd3;
         end
         sc16_pkg::OP_CMPS: calc_flags = alu_f;
         sc16_pkg::OP_ADD, sc16_pkg::OP_ADDI, sc16_pkg::OP_ADDII,
         sc16_pkg::OP_SUB, sc16_pkg::OP_SUBI, sc16_pkg::OP_SUBII: begin
            npop = 2'd1; npush = 2'd1; calc_v0 = alu_r[15:0];
            calc_flags = alu_f; size = 2'd3;
         end
         sc16_pkg::OP_ADDS, sc16_pkg::OP_SUBS: begin
            npop = 2'd2; npush = 2'd1; calc_v0 = alu_r[15:0]; calc_flags = alu_f;
         end
         sc16_pkg::OP_OR, sc16_pkg::OP_ORI, sc16_pkg::OP_ORII,
         sc16_pkg::OP_AND, sc16_pkg::OP_ANDI, sc16_pkg::OP_ANDII,
         sc16_pkg::OP_XOR, sc16_pkg::OP_XORI, sc16_pkg::OP_XORII: begin
            npop = 2'd1; npush = 2'd1; calc_v0 = lg_r; size = 2'd3;
            calc_flags = {2'b00, lg_r[15], (lg_r == 16'd0)};
         end
         sc16_pkg::OP_ORS, sc16_pkg::OP_ANDS, sc16_pkg::OP_XORS: begin
            npop = 2'd2; npush = 2'd1; calc_v0 = lg_r;
            calc_flags = {2'b00, lg_r[15], (lg_r == 16'd0)};
         end
         sc16_pkg::OP_INV, sc16_pkg::OP_COMP2: begin
            npop = 2'd1; npush = 2'd1; calc_v0 = lg_r;
            calc_flags = {2'b00, lg_r[15], (lg_r == 16'd0)};
         end
         sc16_pkg::OP_JMPZ: begin take = flags_ff[0]; size = 2'd3; end
         sc16_pkg::OP_JMPN: begin take = flags_ff[1]; size = 2'd3; end
         sc16_pkg::OP_JMPC: begin take = flags_ff[2]; size = 2'd3; end
         sc16_pkg::OP_JMPO: begin take = flags_ff[3]; size = 2'd3; end
         sc16_pkg::OP_JMP:  take = 1'b1;
         sc16_pkg::OP_JMPI: begin take = 1'b1; tgt = pi_ff; end
         sc16_pkg::OP_JMPS: begin
            npop = 2'd1; take = 1'b1; tgt = a_eff;
         end
         sc16_pkg::OP_CAST: begin
            size = 2'd3;
            if (a_eff == sc16_pkg::HALT_CODE) begin
               calc_st = sc16_pkg::ST_HALT;
            end
         end
         sc16_pkg::OP_POLL: size = 2'd3;
         sc16_pkg::OP_RRTC, sc16_pkg::OP_RTR: begin
            npop = 2'd1; npush = 2'd1; calc_v0 = rot_r; calc_flags[2] = a_eff[0];
         end
         sc16_pkg::OP_RLTC, sc16_pkg::OP_RTL: begin
            npop = 2'd1; npush = 2'd1; calc_v0 = rot_r; calc_flags[2] = a_eff[15];
         end
         sc16_pkg::OP_FCLR: calc_flags = 4'd0;
         sc16_pkg::OP_FSAV: begin
            npush = 2'd1; calc_v0 = {12'd0, flags_ff};
         end
         sc16_pkg::OP_FLOD: begin
            npop = 2'd1; calc_flags = a_eff[3:0];
         end
         default: begin
            size = 2'd2; calc_st = sc16_pkg::ST_BADOP;
         end
      endcase

      // Stack bookkeeping: pops clamp at empty, then pushes land above.
      under = (sp_ff < sc16_pkg::SP_BITS'(npop));
      base  = under ? '0 : (sp_ff - sc16_pkg::SP_BITS'(npop));
      if (under) begin
         calc_st = sc16_pkg::ST_UNDER;
      end
      calc_plan.w0 = sc16_pkg::STK_IDX_BITS'(base);
      calc_plan.w1 = sc16_pkg::STK_IDX_BITS'(base + sc16_pkg::SP_BITS'(1));
      calc_sp      = base + sc16_pkg::SP_BITS'(npush);
      calc_plan.wr0 = (npush != 2'd0);
      calc_plan.wr1 = (npush == 2'd2);
      if (npop == 2'd0 && npush == 2'd1 &&
          sp_ff >= sc16_pkg::SP_BITS'(sc16_pkg::STACK_WORDS)) begin
         // Full stack: the word is dropped.
         calc_plan.wr0 = 1'b0;
         calc_sp       = sp_ff;
         calc_st       = sc16_pkg::ST_OVER;
      end
      calc_pc = take ? tgt : (pc_ff + {14'd0, size});
   end

   // Sequencer.
   always_comb begin
      state_in  = state_ff;
      pc_in     = pc_ff;
      flags_in  = flags_ff;
      sp_in     = sp_ff;
      status_in = status_ff;
      rbyte_in  = rbyte_ff;
      top_in    = top_ff;
      op_in     = op_ff;
      lo_in     = lo_ff;
      tos_in    = tos_ff;
      sft_in    = sft_ff;
      p_in      = p_ff;
      pi_in     = pi_ff;
      pii_in    = pii_ff;
      v0_in     = v0_ff;
      plan_in   = plan_ff;
      mem_we    = 1'b0;
      mem_addr  = pc_ff;
      mem_wd    = plan_ff.mw_val[7:0];
      stk_we    = 1'b0;
      stk_addr  = sc16_pkg::STK_IDX_BITS'(sp_ff - sc16_pkg::SP_BITS'(1));
      stk_wd    = v0_ff;

      unique case (state_ff)
         sc16_pkg::S_IDLE: begin
            mem_addr = req_chan.address;
            mem_wd   = req_chan.write_byte;
            if (req_chan.valid) begin
               status_in = sc16_pkg::ST_OK;
               rbyte_in  = 8'd0;
               unique case (req_chan.func)
                  sc16_pkg::FN_EXEC:  state_in = sc16_pkg::S_OP;
                  sc16_pkg::FN_WRITE: begin
                     mem_we   = 1'b1;
                     state_in = sc16_pkg::S_TOP;
                  end
                  sc16_pkg::FN_READ:  state_in = sc16_pkg::S_RB;
                  default: begin
                     pc_in    = req_chan.address;
                     state_in = sc16_pkg::S_TOP;
                  end
               endcase
            end
         end
         sc16_pkg::S_RB: begin
            rbyte_in = mem_q;
            state_in = sc16_pkg::S_TOP;
         end
         sc16_pkg::S_OP: state_in = sc16_pkg::S_P0;
         sc16_pkg::S_P0: begin
            op_in    = mem_q;
            tos_in   = stk_q;
            mem_addr = pc_ff + 16'd1;
            stk_addr = sc16_pkg::STK_IDX_BITS'(sp_ff - sc16_pkg::SP_BITS'(2));
            state_in = sc16_pkg::S_P1;
         end
         sc16_pkg::S_P1: begin
            lo_in    = mem_q;
            sft_in   = stk_q;
            mem_addr = pc_ff + 16'd2;
            state_in = sc16_pkg::S_I0;
         end
         sc16_pkg::S_I0: begin
            p_in     = {mem_q, lo_ff};
            mem_addr = {mem_q, lo_ff};
            state_in = sc16_pkg::S_I1;
         end
         sc16_pkg::S_I1: begin
            lo_in    = mem_q;
            mem_addr = p_ff + 16'd1;
            state_in = sc16_pkg::S_J0;
         end
         sc16_pkg::S_J0: begin
            pi_in    = {mem_q, lo_ff};
            mem_addr = {mem_q, lo_ff};
            state_in = sc16_pkg::S_J1;
         end
         sc16_pkg::S_J1: begin
            lo_in    = mem_q;
            mem_addr = pi_ff + 16'd1;
            state_in = sc16_pkg::S_CAP;
         end
         sc16_pkg::S_CAP: begin
            pii_in   = {mem_q, lo_ff};
            state_in = sc16_pkg::S_CALC;
         end
         sc16_pkg::S_CALC: begin
            plan_in   = calc_plan;
            v0_in     = calc_v0;
            pc_in     = calc_pc;
            flags_in  = calc_flags;
            sp_in     = calc_sp;
            status_in = calc_st;
            state_in  = calc_plan.rd16 ? sc16_pkg::S_SR0 : sc16_pkg::S_W1;
         end
         sc16_pkg::S_SR0: begin
            mem_addr = plan_ff.mw_addr;
            state_in = sc16_pkg::S_SR1;
         end
         sc16_pkg::S_SR1: begin
            lo_in    = mem_q;
            mem_addr = plan_ff.mw_addr + 16'd1;
            state_in = sc16_pkg::S_SR2;
         end
         sc16_pkg::S_SR2: begin
            v0_in    = {mem_q, lo_ff};
            state_in = sc16_pkg::S_W1;
         end
         sc16_pkg::S_W1: begin
            stk_we   = plan_ff.wr0;
            stk_addr = plan_ff.w0;
            mem_we   = plan_ff.mw;
            mem_addr = plan_ff.mw_addr;
            state_in = sc16_pkg::S_W2;
         end
         sc16_pkg::S_W2: begin
            stk_we   = plan_ff.wr1;
            stk_addr = plan_ff.w1;
            stk_wd   = plan_ff.v1;
            mem_we   = plan_ff.mw;
            mem_addr = plan_ff.mw_addr + 16'd1;
            mem_wd   = plan_ff.mw_val[15:8];
            state_in = sc16_pkg::S_TOP;
         end
         sc16_pkg::S_TOP: state_in = sc16_pkg::S_TOPC;
         sc16_pkg::S_TOPC: begin
            top_in   = (sp_ff >= sc16_pkg::SP_BITS'(1)) ? stk_q : sc16_pkg::ALL_ONES;
            state_in = sc16_pkg::S_RESP;
         end
         sc16_pkg::S_RESP: begin
            if (rsp_chan.ready) begin
               state_in = sc16_pkg::S_IDLE;
            end
         end
         default: state_in = sc16_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sc16_pkg::S_IDLE;
         pc_ff    <= 16'd0;
         flags_ff <= 4'd0;
         sp_ff    <= '0;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
         flags_ff <= flags_in;
         sp_ff    <= sp_in;
      end
      status_ff <= status_in;
      rbyte_ff  <= rbyte_in;
      top_ff    <= top_in;
      op_ff     <= op_in;
      lo_ff     <= lo_in;
      tos_ff    <= tos_in;
      sft_ff    <= sft_in;
      p_ff      <= p_in;
      pi_ff     <= pi_in;
      pii_ff    <= pii_in;
      v0_ff     <= v0_in;
      plan_ff   <= plan_in;
   end

   assign req_chan.ready       = (state_ff == sc16_pkg::S_IDLE);
   assign rsp_chan.valid       = (state_ff == sc16_pkg::S_RESP);
   assign rsp_chan.pc_out      = pc_ff;
   assign rsp_chan.flags_out   = flags_ff;
   assign rsp_chan.status      = status_ff;
   assign rsp_chan.read_byte   = rbyte_ff;
   assign rsp_chan.top_word    = top_ff;
   assign rsp_chan.stack_depth = sc16_pkg::DEPTH_W'(sp_ff);

`include "stack_cpu16_step_macros.svh"

   // Never take a new command while a response is pending.
   `SC16_ASSERT_IMP(a_one_at_a_time, clock, reset, req_chan.ready, !rsp_chan.valid, "ready with response pending")
   // An accepted command drops ready on the next cycle.
   `SC16_ASSERT_NXT(a_busy_after_accept, clock, reset, req_chan.valid && req_chan.ready, !req_chan.ready, "still ready after accept")
   // The reported stack depth never exceeds the stack size.
   `SC16_ASSERT_IMP(a_depth_bound, clock, reset, rsp_chan.valid, sp_ff <= sc16_pkg::SP_BITS'(sc16_pkg::STACK_WORDS), "stack depth out of range")

endmodule

[sim/tb_stack_cpu16_step.sv]
// Self-checking testbench for the 16-bit stack processor step block.
module tb_stack_cpu16_step;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 4000000;
   localparam int TARGET_ITEMS = 1400;

   // One response item as the block reports it.
   typedef struct {
      logic [15:0] pc;
      logic [3:0]  flags;
      logic [2:0]  status;
      logic [7:0]  rbyte;
      logic [15:0] top;
      logic [6:0]  depth;
   } reply_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   cycles = 0;
   int   errors = 0;
   int   items_sent = 0;

   stack_cpu16_req_if req_chan ();
   stack_cpu16_rsp_if rsp_chan ();

   stack_cpu16_step uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #5 clock = ~clock;

   // The cycle counter guards against a hung handshake.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Shadow of the processor state. The written map records which memory
   // bytes hold a defined value, so that no instruction ever fetches from a
   // byte that was never stored.
   logic [7:0]  shadow_mem [0:65535];
   bit          written    [0:65535];
   logic [15:0] shadow_stack [0:sc16_pkg::STACK_WORDS-1];
   int          shadow_sp = 0;
   logic [15:0] shadow_pc = 16'h0000;
   logic [3:0]  shadow_flags = 4'h0;
   logic [2:0]  step_status;

   reply_type replies_due [$];

   function automatic logic [15:0] mem_word(logic [15:0] a);
      logic [15:0] a1;
      a1 = a + 16'd1;
      return {shadow_mem[a1], shadow_mem[a]};
   endfunction

   function automatic void mem_store_word(logic [15:0] a, logic [15:0] v);
      logic [15:0] a1;
      a1 = a + 16'd1;
      shadow_mem[a] = v[7:0];
      shadow_mem[a1] = v[15:8];
      written[a] = 1'b1;
      written[a1] = 1'b1;
   endfunction

   // A pop on an empty stack reports underflow and yields all ones.
   function automatic logic [15:0] stack_pop();
      if (shadow_sp == 0) begin
         step_status = sc16_pkg::ST_UNDER;
         return sc16_pkg::ALL_ONES;
      end
      shadow_sp--;
      return shadow_stack[shadow_sp];
   endfunction

   // A push onto a full stack is dropped and reports overflow.
   function automatic void stack_push(logic [15:0] v);
      if (shadow_sp >= sc16_pkg::STACK_WORDS) begin
         step_status = sc16_pkg::ST_OVER;
         return;
      end
      shadow_stack[shadow_sp] = v;
      shadow_sp++;
   endfunction

   function automatic logic [3:0] zero_neg(logic [15:0] r);
      return {2'b00, r[15], r == 16'h0000};
   endfunction

   // Subtract a - b; carry is the borrow out of the 16-bit result.
   function automatic logic [3:0] sub_flags(logic [15:0] a, logic [15:0] b,
                                            output logic [15:0] r);
      logic [31:0] x;
      logic [3:0]  f;
      x = {16'h0, a} - {16'h0, b};
      r = x[15:0];
      f = zero_neg(r);
      f[2] = |x[19:16];
      f[3] = (a[15] != b[15]) && (r[15] != a[15]);
      return f;
   endfunction

   function automatic logic [3:0] add_flags(logic [15:0] a, logic [15:0] b,
                                            output logic [15:0] r);
      logic [31:0] x;
      logic [3:0]  f;
      x = {16'h0, a} + {16'h0, b};
      r = x[15:0];
      f = zero_neg(r);
      f[2] = |x[19:16];
      f[3] = (a[15] == b[15]) && (r[15] != a[15]);
      return f;
   endfunction

   // Carries out one instruction at the shadow program counter.
   function automatic void run_instruction();
      logic [7:0]  op;
      logic [15:0] pc, p, pi, pii, tos, sft, a, b, r, opnd;
      logic [3:0]  f;
      logic [15:0] size;
      pc = shadow_pc;
      op = shadow_mem[pc];
      p = mem_word(pc + 16'd1);
      pi = mem_word(p);
      pii = mem_word(pi);
      tos = (shadow_sp >= 1) ? shadow_stack[shadow_sp-1] : sc16_pkg::ALL_ONES;
      sft = (shadow_sp >= 2) ? shadow_stack[shadow_sp-2] : sc16_pkg::ALL_ONES;
      f = shadow_flags;
      size = 16'd1;
      r = 16'h0;
      case (op)
         sc16_pkg::OP_CMP, sc16_pkg::OP_ADD, sc16_pkg::OP_SUB,
         sc16_pkg::OP_OR, sc16_pkg::OP_AND, sc16_pkg::OP_XOR: opnd = p;
         sc16_pkg::OP_CMPI, sc16_pkg::OP_ADDI, sc16_pkg::OP_SUBI,
         sc16_pkg::OP_ORI, sc16_pkg::OP_ANDI, sc16_pkg::OP_XORI: opnd = pi;
         sc16_pkg::OP_CMPII, sc16_pkg::OP_ADDII, sc16_pkg::OP_SUBII,
         sc16_pkg::OP_ORII, sc16_pkg::OP_ANDII, sc16_pkg::OP_XORII: opnd = pii;
         default: opnd = 16'h0;
      endcase
      case (op)
         sc16_pkg::OP_NOP: ;
         sc16_pkg::OP_PUSH: begin stack_push(p); size = 16'd3; end
         sc16_pkg::OP_DUP: stack_push(tos);
         sc16_pkg::OP_PUSHI: begin stack_push(pi); size = 16'd3; end
         sc16_pkg::OP_PUSHII: begin stack_push(pii); size = 16'd3; end
         sc16_pkg::OP_PUSHS: begin a = stack_pop(); stack_push(mem_word(a)); end
         sc16_pkg::OP_POPNULL: a = stack_pop();
         sc16_pkg::OP_SWP: begin
            a = stack_pop(); b = stack_pop(); stack_push(a); stack_push(b);
         end
         sc16_pkg::OP_POPI: begin mem_store_word(p, stack_pop()); size = 16'd3; end
         sc16_pkg::OP_POPII: begin mem_store_word(pi, stack_pop()); size = 16'd3; end
         sc16_pkg::OP_POPS: begin
            a = stack_pop(); b = stack_pop(); mem_store_word(a, b);
         end
         sc16_pkg::OP_CMP, sc16_pkg::OP_CMPI, sc16_pkg::OP_CMPII: begin
            f = sub_flags(tos, opnd, r); size = 16'd3;
         end
         sc16_pkg::OP_CMPS: f = sub_flags(sft, tos, r);
         sc16_pkg::OP_ADD, sc16_pkg::OP_ADDI, sc16_pkg::OP_ADDII: begin
            b = stack_pop(); f = add_flags(opnd, b, r); stack_push(r); size = 16'd3;
         end
         sc16_pkg::OP_ADDS: begin
            a = stack_pop(); b = stack_pop(); f = add_flags(a, b, r); stack_push(r);
         end
         sc16_pkg::OP_SUB, sc16_pkg::OP_SUBI, sc16_pkg::OP_SUBII: begin
            b = stack_pop(); f = sub_flags(b, opnd, r); stack_push(r); size = 16'd3;
         end
         sc16_pkg::OP_SUBS: begin
            b = stack_pop(); a = stack_pop(); f = sub_flags(a, b, r); stack_push(r);
         end
         sc16_pkg::OP_OR, sc16_pkg::OP_ORI, sc16_pkg::OP_ORII: begin
            r = stack_pop() | opnd; f = zero_neg(r); stack_push(r); size = 16'd3;
         end
         sc16_pkg::OP_ORS: begin
            a = stack_pop(); r = a | stack_pop(); f = zero_neg(r); stack_push(r);
         end
         sc16_pkg::OP_AND, sc16_pkg::OP_ANDI, sc16_pkg::OP_ANDII: begin
            r = stack_pop() & opnd; f = zero_neg(r); stack_push(r); size = 16'd3;
         end
         sc16_pkg::OP_ANDS: begin
            a = stack_pop(); r = a & stack_pop(); f = zero_neg(r); stack_push(r);
         end
         sc16_pkg::OP_XOR, sc16_pkg::OP_XORI, sc16_pkg::OP_XORII: begin
            r = stack_pop() ^ opnd; f = zero_neg(r); stack_push(r); size = 16'd3;
         end
         sc16_pkg::OP_XORS: begin
            a = stack_pop(); r = a ^ stack_pop(); f = zero_neg(r); stack_push(r);
         end
         sc16_pkg::OP_JMPZ, sc16_pkg::OP_JMPN, sc16_pkg::OP_JMPC,
         sc16_pkg::OP_JMPO: begin
            if (f[op - sc16_pkg::OP_JMPZ]) begin
               pc = p; size = 16'd0;
            end else begin
               size = 16'd3;
            end
         end
         sc16_pkg::OP_JMP: begin pc = p; size = 16'd0; end
         sc16_pkg::OP_JMPI: begin pc = pi; size = 16'd0; end
         sc16_pkg::OP_JMPS: begin pc = stack_pop(); size = 16'd0; end
         sc16_pkg::OP_CAST: begin
            if (tos == sc16_pkg::HALT_CODE) step_status = sc16_pkg::ST_HALT;
            size = 16'd3;
         end
         sc16_pkg::OP_POLL: size = 16'd3;
         sc16_pkg::OP_RRTC: begin
            a = stack_pop(); r = {f[2], a[15:1]}; f[2] = a[0]; stack_push(r);
         end
         sc16_pkg::OP_RLTC: begin
            a = stack_pop(); r = {a[14:0], f[2]}; f[2] = a[15]; stack_push(r);
         end
         sc16_pkg::OP_RTR: begin
            a = stack_pop(); r = {1'b0, a[15:1]}; f[2] = a[0]; stack_push(r);
         end
         sc16_pkg::OP_RTL: begin
            a = stack_pop(); r = {a[14:0], 1'b0}; f[2] = a[15]; stack_push(r);
         end
         sc16_pkg::OP_INV: begin r = ~stack_pop(); stack_push(r); f = zero_neg(r); end
         sc16_pkg::OP_COMP2: begin
            r = ~stack_pop() + 16'd1; stack_push(r); f = zero_neg(r);
         end
         sc16_pkg::OP_FCLR: f = 4'h0;
         sc16_pkg::OP_FSAV: stack_push({12'h0, f});
         sc16_pkg::OP_FLOD: begin a = stack_pop(); f = a[3:0]; end
         default: begin size = 16'd2; step_status = sc16_pkg::ST_BADOP; end
      endcase
      shadow_flags = f;
      shadow_pc = pc + size;
   endfunction

   // Advances the shadow state by one command and returns the reply due.
   function automatic reply_type predict_reply(logic [1:0] func, logic [15:0] addr,
                                               logic [7:0] wbyte);
      reply_type rep;
      rep.rbyte = 8'h00;
      step_status = sc16_pkg::ST_OK;
      case (func)
         sc16_pkg::FN_EXEC: run_instruction();
         sc16_pkg::FN_WRITE: begin
            shadow_mem[addr] = wbyte;
            written[addr] = 1'b1;
         end
         sc16_pkg::FN_READ: rep.rbyte = shadow_mem[addr];
         default: shadow_pc = addr;
      endcase
      rep.pc = shadow_pc;
      rep.flags = shadow_flags;
      rep.status = step_status;
      rep.top = (shadow_sp >= 1) ? shadow_stack[shadow_sp-1] : sc16_pkg::ALL_ONES;
      rep.depth = shadow_sp[6:0];
      return rep;
   endfunction

   // Drives one command item; the caller is always at a falling edge here.
   task automatic send_command(logic [1:0] func, logic [15:0] addr, logic [7:0] wbyte);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.func <= func;
      req_chan.address <= addr;
      req_chan.write_byte <= wbyte;
      req_chan.valid <= 1'b1;
      do @(posedge clock); while (!req_chan.ready);
      replies_due.push_back(predict_reply(func, addr, wbyte));
      items_sent++;
      @(negedge clock);
   endtask

   // Gives a byte a defined value if it has none yet.
   task automatic fill_byte(logic [15:0] a);
      if (!written[a]) send_command(sc16_pkg::FN_WRITE, a, 8'($urandom_range(0, 255)));
   endtask

   task automatic fill_word(logic [15:0] a);
      fill_byte(a);
      fill_byte(a + 16'd1);
   endtask

   // Places an instruction at the current program counter, makes every
   // byte it will fetch defined, then executes it.
   task automatic issue_op(logic [7:0] op, logic [15:0] param);
      logic [15:0] p, pi;
      send_command(sc16_pkg::FN_WRITE, shadow_pc, op);
      send_command(sc16_pkg::FN_WRITE, shadow_pc + 16'd1, param[7:0]);
      send_command(sc16_pkg::FN_WRITE, shadow_pc + 16'd2, param[15:8]);
      p = mem_word(shadow_pc + 16'd1);
      fill_word(p);
      pi = mem_word(p);
      fill_word(pi);
      if (op == sc16_pkg::OP_PUSHS) begin
         fill_word((shadow_sp >= 1) ? shadow_stack[shadow_sp-1] : sc16_pkg::ALL_ONES);
      end
      send_command(sc16_pkg::FN_EXEC, 16'h0000, 8'h00);
   endtask

   // The receiver stalls a random number of cycles before each item and
   // compares every field against the oldest reply due.
   initial begin
      reply_type want;
      int stall;
      rsp_chan.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
         if (replies_due.size() == 0) begin
            $error("response item arrived with no reply due");
            errors++;
         end else begin
            want = replies_due.pop_front();
            if (rsp_chan.pc_out !== want.pc) begin
               $error("pc_out expected %h actual %h", want.pc, rsp_chan.pc_out);
               errors++;
            end
            if (rsp_chan.flags_out !== want.flags) begin
               $error("flags_out expected %h actual %h", want.flags, rsp_chan.flags_out);
               errors++;
            end
            if (rsp_chan.status !== want.status) begin
               $error("status expected %0d actual %0d", want.status, rsp_chan.status);
               errors++;
            end
            if (rsp_chan.read_byte !== want.rbyte) begin
               $error("read_byte expected %h actual %h", want.rbyte, rsp_chan.read_byte);
               errors++;
            end
            if (rsp_chan.top_word !== want.top) begin
               $error("top_word expected %h actual %h", want.top, rsp_chan.top_word);
               errors++;
            end
            if (rsp_chan.stack_depth !== want.depth) begin
               $error("stack_depth expected %0d actual %0d", want.depth,
                      rsp_chan.stack_depth);
               errors++;
            end
         end
         @(negedge clock);
      end
   end

   // Memory commands at the address extremes, with all-zero and all-one
   // bytes, and a program counter set to the top of memory.
   task automatic test_memory_commands();
      send_command(sc16_pkg::FN_WRITE, 16'h0000, 8'hff);
      send_command(sc16_pkg::FN_WRITE, 16'hffff, 8'h00);
      send_command(sc16_pkg::FN_READ, 16'h0000, 8'h00);
      send_command(sc16_pkg::FN_READ, 16'hffff, 8'hff);
      send_command(sc16_pkg::FN_SETPC, 16'hffff, 8'h00);
   endtask

   // Stack corner cases: a pop from the empty stack, an instruction whose
   // parameter wraps past the top of memory, the halt request and an
   // unknown opcode.
   task automatic test_special_cases();
      issue_op(sc16_pkg::OP_POPNULL, 16'h0000);
      issue_op(sc16_pkg::OP_DUP, 16'h0000);
      issue_op(sc16_pkg::OP_PUSH, 16'd99);
      issue_op(sc16_pkg::OP_CAST, 16'h0000);
      issue_op(sc16_pkg::OP_POLL, 16'h0000);
      issue_op(8'hff, 16'h0000);
      issue_op(sc16_pkg::OP_CMPS, 16'h0000);
   endtask

   // Operands favor a small window so that indirections land on bytes
   // already defined, with some full-range values and extremes mixed in.
   function automatic logic [15:0] pick_param();
      case ($urandom_range(0, 9))
         0: return 16'hffff;
         1: return 16'h0000;
         2: return 16'h8000;
         3, 4: return 16'($urandom_range(0, 65535));
         default: return 16'($urandom_range(16'h0100, 16'h01ff));
      endcase
   endfunction

   // Pushes past the stack limit so that the extra words are dropped with
   // an overflow report.
   task automatic test_stack_limits();
      repeat (sc16_pkg::STACK_WORDS + 3 - shadow_sp) begin
         issue_op(sc16_pkg::OP_PUSH, pick_param());
      end
   endtask

   // Random programs with memory commands mixed in as noise.
   task automatic test_random_programs();
      logic [7:0] op;
      logic [15:0] a;
      int n;
      while (items_sent < TARGET_ITEMS) begin
         n = $urandom_range(0, 99);
         if (n < 5) begin
            send_command(sc16_pkg::FN_SETPC, 16'($urandom_range(0, 65535)), 8'h00);
         end else if (n < 9) begin
            send_command(sc16_pkg::FN_WRITE, 16'($urandom_range(0, 65535)),
                         8'($urandom_range(0, 255)));
         end else if (n < 13) begin
            a = 16'($urandom_range(0, 65535));
            fill_byte(a);
            send_command(sc16_pkg::FN_READ, a, 8'h00);
         end else begin
            if ($urandom_range(0, 19) == 0) op = 8'($urandom_range(0, 255));
            else if (shadow_sp < 3 && $urandom_range(0, 1) == 0) op = sc16_pkg::OP_PUSH;
            else op = 8'($urandom_range(0, 52));
            issue_op(op, pick_param());
         end
      end
   endtask

   initial begin
      req_chan.valid = 1'b0;
      req_chan.func = sc16_pkg::FN_EXEC;
      req_chan.address = 16'h0000;
      req_chan.write_byte = 8'h00;
      for (int i = 0; i < 65536; i++) begin
         written[i] = 1'b0;
         shadow_mem[i] = 8'h00;
      end
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_memory_commands();
      test_special_cases();
      test_stack_limits();
      test_random_programs();
      req_chan.valid <= 1'b0;

      // Drain: every reply must arrive, and anything unexpected that shows up
      // afterwards is still caught before the verdict.
      while (replies_due.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
